// ===== rtl/brec_pkg.sv =====
// ---------------------------------------------------------------------------
// brec_pkg: shared types and constants
// Field widths, register indexes and control structs of the burst-rate
// emission counter.
// ---------------------------------------------------------------------------
`default_nettype none

package brec_pkg;

  // Fixed field widths
  localparam int ELAPSED_W = 20;  // tick time, unsigned fixed point
  localparam int RAND_W    = 16;  // random fraction, Q0.16
  localparam int REG_W     = 32;  // configuration register width
  localparam int CTR_W     = 33;  // signed countdown width
  localparam int CFG_IDX_W = 3;   // register index width

  // Parameter defaults
  localparam int TIME_FRAC_BITS_DEF = 16;
  localparam int COUNT_BITS_DEF     = 16;

  // Register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_EMISSION_RATE = 3'd0,
    REG_DURATION_MIN  = 3'd1,
    REG_DURATION_MAX  = 3'd2,
    REG_REPEAT_MIN    = 3'd3,
    REG_REPEAT_MAX    = 3'd4,
    REG_START_DELAY   = 3'd5,
    REG_START_ENABLED = 3'd6
  } reg_idx_t;

  // Current register contents
  typedef struct packed {
    logic [REG_W-1:0] emission_rate;
    logic [REG_W-1:0] duration_min;
    logic [REG_W-1:0] duration_max;
    logic [REG_W-1:0] repeat_min;
    logic [REG_W-1:0] repeat_max;
    logic [REG_W-1:0] start_delay;
    logic             start_enabled;
  } cfg_t;

  // State reload strobes that go with a register write
  typedef struct packed {
    logic             burst;
    logic             pause;
    logic             start;
    logic             enable;
    logic [REG_W-1:0] value;
  } load_t;

endpackage

`default_nettype wire

// ===== rtl/brec_tick_if.sv =====
// ---------------------------------------------------------------------------
// brec_tick_if: tick input channel
// Valid/ready channel carrying elapsed time and a random fraction.
// ---------------------------------------------------------------------------
`default_nettype none

interface brec_tick_if;
  logic                          valid;
  logic                          ready;
  logic [brec_pkg::ELAPSED_W-1:0] elapsed;
  logic [brec_pkg::RAND_W-1:0]    rand_frac;

  modport source (output valid, output elapsed, output rand_frac, input ready);
  modport sink   (input valid, input elapsed, input rand_frac, output ready);
endinterface

`default_nettype wire

// ===== rtl/brec_result_if.sv =====
// ---------------------------------------------------------------------------
// brec_result_if: result output channel
// Valid/ready channel carrying the emit count and the enabled state.
// ---------------------------------------------------------------------------
`default_nettype none

interface brec_result_if #(
  parameter int COUNT_BITS = brec_pkg::COUNT_BITS_DEF
);
  logic                  valid;
  logic                  ready;
  logic [COUNT_BITS-1:0] emit_count;
  logic                  now_enabled;

  modport source (output valid, output emit_count, output now_enabled, input ready);
  modport sink   (input valid, input emit_count, input now_enabled, output ready);
endinterface

`default_nettype wire

// ===== rtl/brec_cfg_if.sv =====
// ---------------------------------------------------------------------------
// brec_cfg_if: configuration write channel
// Valid/ready channel carrying a register index and write data.
// ---------------------------------------------------------------------------
`default_nettype none

interface brec_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [brec_pkg::CFG_IDX_W-1:0] index;
  logic [brec_pkg::REG_W-1:0]     data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/brec_cfg_regs.sv =====
// ---------------------------------------------------------------------------
// brec_cfg_regs: configuration register file
// Holds the seven registers and raises reload strobes for the countdowns.
// ---------------------------------------------------------------------------
`default_nettype none

module brec_cfg_regs (
  input  wire logic          clk,
  input  wire logic          rst,
  brec_cfg_if.sink           cfg,
  output brec_pkg::cfg_t     regs,
  output brec_pkg::load_t    load
);

  logic wr;

  assign cfg.ready = 1'b1;
  assign wr        = cfg.valid;

  // Register writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      regs.emission_rate <= '0;
      regs.duration_min  <= '0;
      regs.duration_max  <= '0;
      regs.repeat_min    <= '0;
      regs.repeat_max    <= '0;
      regs.start_delay   <= '0;
      regs.start_enabled <= 1'b1;
    end else if (wr) begin
      case (brec_pkg::reg_idx_t'(cfg.index))
        brec_pkg::REG_EMISSION_RATE: regs.emission_rate <= cfg.data;
        brec_pkg::REG_DURATION_MIN:  regs.duration_min  <= cfg.data;
        brec_pkg::REG_DURATION_MAX:  regs.duration_max  <= cfg.data;
        brec_pkg::REG_REPEAT_MIN:    regs.repeat_min    <= cfg.data;
        brec_pkg::REG_REPEAT_MAX:    regs.repeat_max    <= cfg.data;
        brec_pkg::REG_START_DELAY:   regs.start_delay   <= cfg.data;
        brec_pkg::REG_START_ENABLED: regs.start_enabled <= cfg.data[0];
        default: ;
      endcase
    end
  end

  // Reload strobes, same cycle as the write
  always_comb begin
    load.burst  = wr && (cfg.index == brec_pkg::REG_DURATION_MIN);
    load.pause  = wr && (cfg.index == brec_pkg::REG_REPEAT_MIN);
    load.start  = wr && (cfg.index == brec_pkg::REG_START_DELAY);
    load.enable = wr && (cfg.index == brec_pkg::REG_START_ENABLED);
    load.value  = cfg.data;
  end

endmodule

`default_nettype wire

// ===== rtl/brec_draw.sv =====
// ---------------------------------------------------------------------------
// brec_draw: random interval draw
// Returns lo + (hi - lo) * frac, truncated toward lo, for either ordering.
// ---------------------------------------------------------------------------
`default_nettype none

module brec_draw (
  input  wire logic [brec_pkg::REG_W-1:0]  lo,
  input  wire logic [brec_pkg::REG_W-1:0]  hi,
  input  wire logic [brec_pkg::RAND_W-1:0] frac,
  output      logic [brec_pkg::REG_W-1:0]  value
);

  localparam int PROD_W = brec_pkg::REG_W + brec_pkg::RAND_W;

  logic                       hi_ge;
  logic [brec_pkg::REG_W-1:0] span;
  logic [PROD_W-1:0]          prod;
  logic [brec_pkg::REG_W-1:0] step;

  // One 32x16 multiply, then offset from lo toward hi
  always_comb begin
    hi_ge = (hi >= lo);
    span  = hi_ge ? (hi - lo) : (lo - hi);
    prod  = PROD_W'(span) * PROD_W'(frac);
    step  = prod[PROD_W-1:brec_pkg::RAND_W];
    value = hi_ge ? (lo + step) : (lo - step);
  end

endmodule

`default_nettype wire

// ===== rtl/brec_engine.sv =====
// ---------------------------------------------------------------------------
// brec_engine: tick processing pipeline
// Input register, combinational rate accumulate and burst, pause and start
// countdown update, result register.
// ---------------------------------------------------------------------------
`default_nettype none

module brec_engine #(
  parameter int TIME_FRAC_BITS = brec_pkg::TIME_FRAC_BITS_DEF,
  parameter int COUNT_BITS     = brec_pkg::COUNT_BITS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  brec_tick_if.sink                        tick,
  brec_result_if.source                    result,
  input  wire brec_pkg::cfg_t              regs,
  input  wire brec_pkg::load_t             load,
  input  wire logic [brec_pkg::REG_W-1:0]  burst_draw,
  input  wire logic [brec_pkg::REG_W-1:0]  pause_draw,
  output      logic [brec_pkg::RAND_W-1:0] frac_cur
);

  localparam int PROD_W  = brec_pkg::REG_W + brec_pkg::ELAPSED_W;
  localparam int SUM_W   = PROD_W - TIME_FRAC_BITS + 1;
  localparam int EXT_W   = 64;

  // Input stage
  logic                            in_valid;
  logic [brec_pkg::ELAPSED_W-1:0]  elapsed_q;
  logic [brec_pkg::RAND_W-1:0]     frac_q;

  // Result stage
  logic                  out_valid;
  logic [COUNT_BITS-1:0] emit_count_q;
  logic                  now_enabled_q;

  // Tick state
  logic                            enabled_flag, enabled_flag_next;
  logic [TIME_FRAC_BITS-1:0]       fraction_left, fraction_left_next;
  logic signed [brec_pkg::CTR_W-1:0] burst_left, burst_left_next;
  logic signed [brec_pkg::CTR_W-1:0] pause_left, pause_left_next;
  logic signed [brec_pkg::CTR_W-1:0] start_left, start_left_next;
  logic [COUNT_BITS-1:0]           count_next;

  logic                            fire;
  logic [PROD_W-1:0]               prod;
  logic [SUM_W-1:0]                sum;
  logic [EXT_W-1:0]                whole_ext;
  logic signed [brec_pkg::CTR_W-1:0] el_s;
  logic signed [brec_pkg::CTR_W-1:0] burst_dec, pause_dec, start_dec;

  assign fire         = in_valid && (!out_valid || result.ready);
  assign tick.ready   = !in_valid || fire;
  assign frac_cur     = frac_q;

  assign result.valid       = out_valid;
  assign result.emit_count  = emit_count_q;
  assign result.now_enabled = now_enabled_q;

  // Rate accumulate and countdown update for the tick in the input stage
  always_comb begin
    prod      = PROD_W'(regs.emission_rate) * PROD_W'(elapsed_q);
    sum       = SUM_W'(prod >> TIME_FRAC_BITS) + SUM_W'(fraction_left);
    whole_ext = EXT_W'(sum[SUM_W-1:TIME_FRAC_BITS]);
    el_s      = $signed(brec_pkg::CTR_W'(elapsed_q));
    burst_dec = burst_left - el_s;
    pause_dec = pause_left - el_s;
    start_dec = start_left - el_s;

    enabled_flag_next  = enabled_flag;
    fraction_left_next = fraction_left;
    burst_left_next    = burst_left;
    pause_left_next    = pause_left;
    start_left_next    = start_left;
    count_next         = '0;

    if (enabled_flag) begin
      fraction_left_next = sum[TIME_FRAC_BITS-1:0];
      // saturate whole part at the count width
      if (|whole_ext[EXT_W-1:COUNT_BITS]) begin
        count_next = '1;
      end else begin
        count_next = whole_ext[COUNT_BITS-1:0];
      end
      if (regs.duration_max != '0) begin
        burst_left_next = burst_dec;
        if (burst_dec <= 0) begin
          enabled_flag_next = 1'b0;
          pause_left_next   = $signed(brec_pkg::CTR_W'(pause_draw));
        end
      end
    end else begin
      // pause countdown
      if (regs.repeat_max != '0) begin
        pause_left_next = pause_dec;
        if (pause_dec <= 0) begin
          enabled_flag_next = 1'b1;
          burst_left_next   = $signed(brec_pkg::CTR_W'(burst_draw));
        end
      end
      // start countdown
      if (start_left != 0) begin
        start_left_next = start_dec;
        if (start_dec <= 0) begin
          enabled_flag_next = 1'b1;
          burst_left_next   = $signed(brec_pkg::CTR_W'(burst_draw));
          start_left_next   = '0;
        end
      end
    end
  end

  // Control and tick state
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid      <= 1'b0;
      out_valid     <= 1'b0;
      enabled_flag  <= 1'b1;
      fraction_left <= '0;
      burst_left    <= '0;
      pause_left    <= '0;
      start_left    <= '0;
    end else begin
      if (tick.valid && tick.ready) begin
        in_valid <= 1'b1;
      end else if (fire) begin
        in_valid <= 1'b0;
      end

      if (fire) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end

      if (fire) begin
        fraction_left <= fraction_left_next;
      end

      // register writes reload the matching state, otherwise a tick updates it
      if (load.burst) begin
        burst_left <= $signed(brec_pkg::CTR_W'(load.value));
      end else if (fire) begin
        burst_left <= burst_left_next;
      end
      if (load.pause) begin
        pause_left <= $signed(brec_pkg::CTR_W'(load.value));
      end else if (fire) begin
        pause_left <= pause_left_next;
      end
      if (load.start) begin
        start_left <= $signed(brec_pkg::CTR_W'(load.value));
      end else if (fire) begin
        start_left <= start_left_next;
      end
      if (load.enable) begin
        enabled_flag <= load.value[0];
      end else if (fire) begin
        enabled_flag <= enabled_flag_next;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (tick.valid && tick.ready) begin
      elapsed_q <= tick.elapsed;
      frac_q    <= tick.rand_frac;
    end
    if (fire) begin
      emit_count_q  <= count_next;
      now_enabled_q <= enabled_flag_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/burst_rate_emission_counter.sv =====
// ---------------------------------------------------------------------------
// burst_rate_emission_counter: fractional rate accumulator with burst timer
// Emits whole items due per tick and switches between bursts and pauses.
// ---------------------------------------------------------------------------
//
//   channel  dir  payload                    beat taken when
//   -------  ---  -------------------------  --------------------------
//   tick     in   elapsed, rand_frac         tick.valid & tick.ready
//   result   out  emit_count, now_enabled    result.valid & result.ready
//   cfg      in   index, data                cfg.valid & cfg.ready
//
// One tick per cycle sustained while results are taken; a tick beat loads
// the input register, and the tick moves on into the result register once
// that is free or being read. The path between the two registers holds the
// 32x20 rate multiply and, in parallel, the two 32x16 interval draws.
// rst is synchronous; it loads the register reset values and empties both
// stages. A stalled result holds the pipeline; the input stage takes a beat
// during the wait only while it is empty. cfg.ready is always high.
// ---------------------------------------------------------------------------
`default_nettype none

module burst_rate_emission_counter #(
  parameter int TIME_FRAC_BITS = brec_pkg::TIME_FRAC_BITS_DEF,
  parameter int COUNT_BITS     = brec_pkg::COUNT_BITS_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst,
  brec_tick_if.sink       tick,
  brec_result_if.source   result,
  brec_cfg_if.sink        cfg
);

  brec_pkg::cfg_t              regs;
  brec_pkg::load_t             load;
  logic [brec_pkg::REG_W-1:0]  burst_draw;
  logic [brec_pkg::REG_W-1:0]  pause_draw;
  logic [brec_pkg::RAND_W-1:0] frac_cur;

  // Register file
  brec_cfg_regs u_cfg_regs (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs),
    .load (load)
  );

  // Burst length draw, used on enable
  brec_draw u_burst_draw (
    .lo    (regs.duration_min),
    .hi    (regs.duration_max),
    .frac  (frac_cur),
    .value (burst_draw)
  );

  // Pause length draw, used on disable
  brec_draw u_pause_draw (
    .lo    (regs.repeat_min),
    .hi    (regs.repeat_max),
    .frac  (frac_cur),
    .value (pause_draw)
  );

  // Tick pipeline
  brec_engine #(
    .TIME_FRAC_BITS (TIME_FRAC_BITS),
    .COUNT_BITS     (COUNT_BITS)
  ) u_engine (
    .clk        (clk),
    .rst        (rst),
    .tick       (tick),
    .result     (result),
    .regs       (regs),
    .load       (load),
    .burst_draw (burst_draw),
    .pause_draw (pause_draw),
    .frac_cur   (frac_cur)
  );

endmodule

`default_nettype wire
